FILE: rtl/tfk_pkg.sv
package tfk_pkg;

   // Result status codes, in the order the checks are applied
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_LINK   = 3'd1,
      STATUS_SHORT_LINK = 3'd2,
      STATUS_SHORT_IP   = 3'd3,
      STATUS_NOT_IPV4   = 3'd4,
      STATUS_NOT_TCP    = 3'd5,
      STATUS_BAD_IHL    = 3'd6,
      STATUS_SHORT_TCP  = 3'd7
   } status_type;

   // Link kinds held in the control register
   localparam logic [1:0] LINK_ETHERNET = 2'd0;
   localparam logic [1:0] LINK_COOKED   = 2'd1;

   // Link header lengths and framing constants
   localparam logic [4:0]  ETH_HDR_LEN    = 5'd14;
   localparam logic [4:0]  COOKED_HDR_LEN = 5'd16;
   localparam logic [4:0]  VLAN_HDR_LEN   = 5'd18;
   localparam logic [6:0]  VLAN_MIN_CAP   = 7'd16;
   localparam logic [15:0] VLAN_TPID      = 16'h8100;
   localparam logic [6:0]  TYPE_HI_POS    = 7'd12;
   localparam logic [6:0]  TYPE_LO_POS    = 7'd13;
   localparam logic [6:0]  POS_MAX        = 7'd127;

   // IPv4 header layout, offsets from the start of the IP header
   localparam logic [6:0] IP_VER_OFF   = 7'd0;
   localparam logic [6:0] IP_PROTO_OFF = 7'd9;
   localparam logic [6:0] IP_SRC_OFF   = 7'd12;
   localparam logic [6:0] IP_SRC_END   = 7'd15;
   localparam logic [6:0] IP_DST_OFF   = 7'd16;
   localparam logic [6:0] IP_DST_END   = 7'd19;
   localparam logic [7:0] IP_MIN_HDR   = 8'd20;
   localparam logic [3:0] IPV4_VERSION = 4'd4;
   localparam logic [3:0] IHL_MIN      = 4'd5;
   localparam logic [7:0] PROTO_TCP    = 8'd6;
   localparam logic [6:0] TCP_SPORT_END = 7'd1;
   localparam logic [6:0] TCP_DPORT_END = 7'd3;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] wire_length;
   } in_item_type;

   typedef struct packed {
      logic [6:0]  byte_position;
      logic [4:0]  ip_start;
      logic [7:0]  ethertype_high;
      logic [7:0]  version_ihl;
      logic [7:0]  proto_byte;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] held_length;
   } frame_state_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] low_addr;
      logic [31:0] high_addr;
      logic [15:0] low_port;
      logic [15:0] high_port;
      logic        swapped;
      logic [15:0] frame_length;
   } result_type;

endpackage

FILE: rtl/tfk_in_reg.sv
module tfk_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tfk_pkg::in_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output tfk_pkg::in_item_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   logic                 take;
   tfk_pkg::in_item_type item_ff;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/tfk_tracker.sv
module tfk_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  tfk_pkg::in_item_type     item,
   input  logic [1:0]               link_kind,
   output tfk_pkg::frame_state_type state_next
);

   tfk_pkg::frame_state_type state_ff;
   tfk_pkg::frame_state_type state_in;

   always_comb begin
      tfk_pkg::frame_state_type cur;
      logic [6:0] pos;
      logic [4:0] ip_eff;
      logic [6:0] off;
      logic [6:0] ihl4;
      logic [6:0] t;

      cur = state_ff;
      // Start of frame: drop the old headers, latch length and link header size
      if (item.first_byte) begin
         cur.byte_position  = '0;
         cur.ethertype_high = '0;
         cur.version_ihl    = '0;
         cur.proto_byte     = '0;
         cur.source_addr    = '0;
         cur.dest_addr      = '0;
         cur.source_port    = '0;
         cur.dest_port      = '0;
         cur.held_length    = item.wire_length;
         cur.ip_start       = (link_kind == tfk_pkg::LINK_COOKED) ?
                              tfk_pkg::COOKED_HDR_LEN : tfk_pkg::ETH_HDR_LEN;
      end

      state_in = cur;
      pos      = cur.byte_position;
      ip_eff   = cur.ip_start;
      ihl4     = {1'b0, cur.version_ihl[3:0], 2'b00};
      off      = '0;
      t        = '0;

      if (pos != tfk_pkg::POS_MAX) begin
         if (pos == tfk_pkg::TYPE_HI_POS) begin
            state_in.ethertype_high = item.data_byte;
         end
         // VLAN tag pushes the IP header out by four bytes
         if (pos == tfk_pkg::TYPE_LO_POS && link_kind == tfk_pkg::LINK_ETHERNET &&
             cur.ip_start == tfk_pkg::ETH_HDR_LEN &&
             {cur.ethertype_high, item.data_byte} == tfk_pkg::VLAN_TPID) begin
            ip_eff = tfk_pkg::VLAN_HDR_LEN;
         end
         state_in.ip_start = ip_eff;

         if (pos >= {2'b00, ip_eff}) begin
            off = pos - {2'b00, ip_eff};
            if (off == tfk_pkg::IP_VER_OFF) begin
               state_in.version_ihl = item.data_byte;
            end else if (off == tfk_pkg::IP_PROTO_OFF) begin
               state_in.proto_byte = item.data_byte;
            end else if (off >= tfk_pkg::IP_SRC_OFF && off <= tfk_pkg::IP_SRC_END) begin
               state_in.source_addr = {cur.source_addr[23:0], item.data_byte};
            end else if (off >= tfk_pkg::IP_DST_OFF && off <= tfk_pkg::IP_DST_END) begin
               state_in.dest_addr = {cur.dest_addr[23:0], item.data_byte};
            end
            // Ports follow the IP header as the IHL read so far gives it
            if (off >= ihl4) begin
               t = off - ihl4;
               if (t <= tfk_pkg::TCP_SPORT_END) begin
                  state_in.source_port = {cur.source_port[7:0], item.data_byte};
               end else if (t <= tfk_pkg::TCP_DPORT_END) begin
                  state_in.dest_port = {cur.dest_port[7:0], item.data_byte};
               end
            end
         end
         state_in.byte_position = pos + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule

FILE: rtl/tfk_verdict.sv
module tfk_verdict (
   input  tfk_pkg::frame_state_type state,
   input  logic [1:0]               link_kind,
   output tfk_pkg::result_type      result
);

   always_comb begin
      logic [7:0] cap;
      logic [7:0] hl;
      logic [3:0] ihl;
      logic [7:0] tcp_end;
      logic       swap;
      tfk_pkg::status_type st;

      cap     = {1'b0, state.byte_position};
      hl      = {3'b000, state.ip_start};
      ihl     = state.version_ihl[3:0];
      // Too short to have read the VLAN tag: count a plain Ethernet header
      if (state.ip_start == tfk_pkg::VLAN_HDR_LEN &&
          state.byte_position < tfk_pkg::VLAN_MIN_CAP) begin
         hl = {3'b000, tfk_pkg::ETH_HDR_LEN};
      end
      tcp_end = hl + {2'b00, ihl, 2'b00} + tfk_pkg::IP_MIN_HDR;

      if (link_kind > tfk_pkg::LINK_COOKED) begin
         st = tfk_pkg::STATUS_BAD_LINK;
      end else if (cap < hl) begin
         st = tfk_pkg::STATUS_SHORT_LINK;
      end else if (cap < hl + tfk_pkg::IP_MIN_HDR) begin
         st = tfk_pkg::STATUS_SHORT_IP;
      end else if (state.version_ihl[7:4] != tfk_pkg::IPV4_VERSION) begin
         st = tfk_pkg::STATUS_NOT_IPV4;
      end else if (state.proto_byte != tfk_pkg::PROTO_TCP) begin
         st = tfk_pkg::STATUS_NOT_TCP;
      end else if (ihl < tfk_pkg::IHL_MIN) begin
         st = tfk_pkg::STATUS_BAD_IHL;
      end else if (cap < tcp_end) begin
         st = tfk_pkg::STATUS_SHORT_TCP;
      end else begin
         st = tfk_pkg::STATUS_OK;
      end

      swap = (state.source_addr > state.dest_addr) ||
             (state.source_addr == state.dest_addr && state.source_port > state.dest_port);

      result              = '0;
      result.status       = st;
      result.frame_length = state.held_length;
      if (st == tfk_pkg::STATUS_OK) begin
         result.low_addr  = swap ? state.dest_addr   : state.source_addr;
         result.high_addr = swap ? state.source_addr : state.dest_addr;
         result.low_port  = swap ? state.dest_port   : state.source_port;
         result.high_port = swap ? state.source_port : state.dest_port;
         result.swapped   = swap;
      end
   end

endmodule

FILE: rtl/tcp_flow_key_extractor.sv
// IPv4/TCP flow key extractor.
// req_* carries a captured frame one byte per item; req_first_byte opens a frame
// and samples req_wire_length, req_last_byte closes it. Only the last byte of a
// frame yields a result on rsp_*: a status code, the flow key ordered with the
// lower endpoint first, a swapped flag and the wire length.
// csr_link_kind selects Ethernet (with VLAN detection) or Linux cooked capture;
// write it only while no frame is in flight.
// Throughput: one byte per cycle, with no gap between frames, while rsp_stall
// holds no last byte. A byte sits in the input register, and as it advances it
// is parsed into the frame state and, for a last byte, into the result register.
// The frame state sits in one register bank updated by a single pass of
// header-offset logic, so the byte rate is set by that pass and by rsp_stall.
// Stall: while a result waits on rsp_stall, non-final bytes still flow in;
// only a last byte is held in the input register, which raises req_stall.
// Reset clears the frame state, the link kind (Ethernet) and both valids.
module tcp_flow_key_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_wire_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_low_addr,
   output logic [31:0] rsp_high_addr,
   output logic [15:0] rsp_low_port,
   output logic [15:0] rsp_high_port,
   output logic        rsp_swapped,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_link_kind
);

   logic [1:0]                link_kind_ff;
   tfk_pkg::in_item_type      req_item;
   tfk_pkg::in_item_type      item;
   logic                      item_valid;
   logic                      advance;
   logic                      out_free;
   logic                      load_rsp;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   tfk_pkg::frame_state_type  state_next;
   tfk_pkg::result_type       result;
   tfk_pkg::result_type       result_ff;

   // Control register: link kind
   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff <= tfk_pkg::LINK_ETHERNET;
      end else if (csr_write_enable) begin
         link_kind_ff <= csr_link_kind;
      end
   end

   assign req_item.data_byte   = req_data_byte;
   assign req_item.first_byte  = req_first_byte;
   assign req_item.last_byte   = req_last_byte;
   assign req_item.wire_length = req_wire_length;

   // Result register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // A byte with no result never waits; a last byte waits for a free result slot
   assign advance  = item_valid && (!item.last_byte || out_free);
   assign load_rsp = advance && item.last_byte;

   tfk_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tfk_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .link_kind  (link_kind_ff),
      .state_next (state_next)
   );

   // Judge the frame on the state including its last byte
   tfk_verdict u_verdict (
      .state     (state_next),
      .link_kind (link_kind_ff),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result while stalled; load only on a new last byte
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_low_addr     = result_ff.low_addr;
   assign rsp_high_addr    = result_ff.high_addr;
   assign rsp_low_port     = result_ff.low_port;
   assign rsp_high_port    = result_ff.high_port;
   assign rsp_swapped      = result_ff.swapped;
   assign rsp_frame_length = result_ff.frame_length;

endmodule

FILE: rtl/tfk_checker.sv
module tfk_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_low_addr,
   input logic [31:0] rsp_high_addr,
   input logic [15:0] rsp_low_port,
   input logic [15:0] rsp_high_port,
   input logic        rsp_swapped,
   input logic [15:0] rsp_frame_length
);

   // A stalled item stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // A stalled item keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_low_addr) &&
         $stable(rsp_high_addr) && $stable(rsp_low_port) && $stable(rsp_high_port) &&
         $stable(rsp_swapped) && $stable(rsp_frame_length))
      else $error("rsp payload changed while stalled");

   // Nothing is offered in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // A rejected frame carries an all-zero key
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tfk_pkg::STATUS_OK |->
         rsp_low_addr == 32'd0 && rsp_high_addr == 32'd0 && rsp_low_port == 16'd0 &&
         rsp_high_port == 16'd0 && !rsp_swapped)
      else $error("rejected frame with non-zero key");

   // The key is ordered lower endpoint first
   a_key_order : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tfk_pkg::STATUS_OK |->
         rsp_low_addr < rsp_high_addr ||
         (rsp_low_addr == rsp_high_addr && rsp_low_port <= rsp_high_port))
      else $error("flow key out of order");

endmodule

bind tcp_flow_key_extractor tfk_checker u_tfk_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_low_addr     (rsp_low_addr),
   .rsp_high_addr    (rsp_high_addr),
   .rsp_low_port     (rsp_low_port),
   .rsp_high_port    (rsp_high_port),
   .rsp_swapped      (rsp_swapped),
   .rsp_frame_length (rsp_frame_length)
);
